/* rtl/postfix_expression_evaluator_core_defines.svh */
// Assertion macros for the postfix evaluator core.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_CORE_DEFINES_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_CORE_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define PEE_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Antecedent in one cycle implies the consequent in the same cycle.
`define PEE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/pee_pkg.sv */
// Shared types, constants and codes of the postfix evaluator.
// No dependencies; every RTL file refers to it by scoped names.
`default_nettype none

package pee_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IDX_W       = $clog2(STACK_DEPTH);
  localparam int unsigned DIV_CNT_W   = $clog2(DATA_W);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_DIVZERO   = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] character;
    logic       end_of_expression;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    status_e                  status;
  } out_t;

  // One classified character as handed to the execution side.
  typedef struct packed {
    logic              push_valid;
    logic [DATA_W-1:0] push_value;
    op_e               op;
    logic              last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic valid;
  } queue_status_t;

endpackage

`default_nettype wire

/* rtl/pee_front.sv */
// Front end: accepts characters, builds numbers, emits commands.
// Depends on pee_pkg.
`default_nettype none

module pee_front (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  wire  pee_pkg::in_t    in_data_i,
  input  wire                   queue_full_i,
  output logic                  cmd_push_o,
  output pee_pkg::cmd_t         cmd_o
);

  logic [pee_pkg::DATA_W-1:0] acc_q, acc_d;
  logic                       pend_q, pend_d;
  logic                       is_digit;
  logic [3:0]                 digit;
  logic [7:0]                 diff;
  logic [pee_pkg::DATA_W-1:0] acc_next;
  logic                       accept;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_digit   = (in_data_i.character >= pee_pkg::CH_ZERO) &&
                      (in_data_i.character <= pee_pkg::CH_NINE);
  assign diff       = in_data_i.character - pee_pkg::CH_ZERO;
  assign digit      = diff[3:0];
  // times ten as two shifts and an add, wrapping at the data width
  assign acc_next   = {acc_q[pee_pkg::DATA_W-4:0], 3'b000} +
                      {acc_q[pee_pkg::DATA_W-2:0], 1'b0} +
                      pee_pkg::DATA_W'(digit);

  always_comb begin
    cmd_o.last       = in_data_i.end_of_expression;
    cmd_o.op         = pee_pkg::OP_NONE;
    cmd_o.push_valid = pend_q;
    cmd_o.push_value = acc_q;
    acc_d            = acc_q;
    pend_d           = pend_q;
    if (is_digit) begin
      cmd_o.push_valid = in_data_i.end_of_expression;
      cmd_o.push_value = acc_next;
      acc_d            = acc_next;
      pend_d           = 1'b1;
    end else begin
      case (in_data_i.character)
        pee_pkg::CH_PLUS:  cmd_o.op = pee_pkg::OP_ADD;
        pee_pkg::CH_MINUS: cmd_o.op = pee_pkg::OP_SUB;
        pee_pkg::CH_STAR:  cmd_o.op = pee_pkg::OP_MUL;
        pee_pkg::CH_SLASH: cmd_o.op = pee_pkg::OP_DIV;
        default:           cmd_o.op = pee_pkg::OP_NONE;
      endcase
      acc_d  = '0;
      pend_d = 1'b0;
    end
    if (in_data_i.end_of_expression) begin
      acc_d  = '0;
      pend_d = 1'b0;
    end
  end

  assign cmd_push_o = accept && (cmd_o.push_valid || (cmd_o.op != pee_pkg::OP_NONE) ||
                                 cmd_o.last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      pend_q <= 1'b0;
    end else if (accept) begin
      acc_q  <= acc_d;
      pend_q <= pend_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/pee_queue.sv */
// Short command queue between front and back ends.
// Depends on pee_pkg.
`default_nettype none

module pee_queue (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     push_i,
  input  wire  pee_pkg::cmd_t     cmd_i,
  input  wire                     pop_i,
  output pee_pkg::cmd_t           head_o,
  output pee_pkg::queue_status_t  status_o
);

  pee_pkg::cmd_t              entries_q [pee_pkg::QUEUE_DEPTH];
  logic [pee_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [pee_pkg::QCNT_W-1:0] cnt_q;
  logic                       do_push, do_pop;

  assign status_o.full  = (cnt_q == pee_pkg::QCNT_W'(pee_pkg::QUEUE_DEPTH));
  assign status_o.valid = (cnt_q != '0);
  assign head_o         = entries_q[rd_ptr_q];
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && status_o.valid;

  function automatic logic [pee_pkg::QPTR_W-1:0] ptr_inc(input logic [pee_pkg::QPTR_W-1:0] p);
    if (p == pee_pkg::QPTR_W'(pee_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/pee_div.sv */
// Signed divider truncating toward zero, one quotient bit per cycle.
// Depends on pee_pkg.
`default_nettype none

module pee_div (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         start_i,
  input  wire  [pee_pkg::DATA_W-1:0]  dividend_i,
  input  wire  [pee_pkg::DATA_W-1:0]  divisor_i,
  output logic                        done_o,
  output logic [pee_pkg::DATA_W-1:0]  quotient_o
);

  localparam int unsigned W = pee_pkg::DATA_W;

  logic [W-1:0]                  quo_q, rem_q, den_q;
  logic                          neg_q, busy_q, done_q;
  logic [pee_pkg::DIV_CNT_W-1:0] cnt_q;
  logic [W:0]                    rem_sh, diff;
  logic                          ge;
  logic                          na, nb;

  assign na     = dividend_i[W-1];
  assign nb     = divisor_i[W-1];
  assign rem_sh = {rem_q, quo_q[W-1]};
  assign diff   = rem_sh - {1'b0, den_q};
  assign ge     = !diff[W];

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (W'(0) - quo_q) : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == pee_pkg::DIV_CNT_W'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= na ? (W'(0) - dividend_i) : dividend_i;
      den_q <= nb ? (W'(0) - divisor_i) : divisor_i;
      rem_q <= '0;
      neg_q <= na ^ nb;
    end else if (busy_q) begin
      quo_q <= {quo_q[W-2:0], ge};
      rem_q <= ge ? diff[W-1:0] : rem_sh[W-1:0];
    end
  end

endmodule

`default_nettype wire

/* rtl/pee_back.sv */
// Back end: value stack, operator sequencer and result register.
// Depends on pee_pkg and pee_div.
`default_nettype none

module pee_back (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire  pee_pkg::cmd_t          head_i,
  input  wire  pee_pkg::queue_status_t queue_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output pee_pkg::out_t                out_data_o
);

  localparam int unsigned W = pee_pkg::DATA_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PUSH  = 6'b000010,
    S_FETCH = 6'b000100,
    S_EXEC  = 6'b001000,
    S_DIV   = 6'b010000,
    S_END   = 6'b100000
  } state_e;

  state_e                     state_q, state_d;
  pee_pkg::cmd_t              cmd_q, cmd_d;
  logic [pee_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  pee_pkg::status_e           sticky_q, sticky_d;
  logic [W-1:0]               tos_q, tos_d;
  logic                       out_valid_q, out_valid_d;
  pee_pkg::out_t              out_q, out_d;

  logic [W-1:0]               stack_mem [pee_pkg::STACK_DEPTH];
  logic [W-1:0]               rd_q;
  logic                       mem_we, mem_re;
  logic [pee_pkg::CNT_W-1:0]  cnt_m1, cnt_m2;
  logic [W-1:0]               sum, dif, prod;
  logic                       div_start, div_done;
  logic [W-1:0]               div_quo;
  pee_pkg::status_e           fin_status;

  assign cnt_m1 = cnt_q - 1'b1;
  assign cnt_m2 = cnt_q - 2'd2;
  assign sum    = rd_q + tos_q;
  assign dif    = rd_q - tos_q;
  assign prod   = rd_q * tos_q;

  pee_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rd_q),
    .divisor_i  (tos_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  function automatic state_e after_push(input pee_pkg::cmd_t c);
    if (c.op != pee_pkg::OP_NONE) begin
      return S_FETCH;
    end
    return c.last ? S_END : S_IDLE;
  endfunction

  function automatic state_e after_op(input pee_pkg::cmd_t c);
    return c.last ? S_END : S_IDLE;
  endfunction

  function automatic pee_pkg::status_e raise(input pee_pkg::status_e cur,
                                             input pee_pkg::status_e code);
    return (cur == pee_pkg::ST_OK) ? code : cur;
  endfunction

  always_comb begin
    fin_status = sticky_q;
    if ((sticky_q == pee_pkg::ST_OK) && (cnt_q == '0)) begin
      fin_status = pee_pkg::ST_EMPTY;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    cnt_d       = cnt_q;
    sticky_d    = sticky_q;
    tos_d       = tos_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    pop_o       = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    div_start   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (queue_i.valid) begin
          pop_o = 1'b1;
          cmd_d = head_i;
          if (head_i.push_valid) begin
            state_d = S_PUSH;
          end else begin
            state_d = after_push(head_i);
          end
        end
      end
      S_PUSH: begin
        if (cnt_q == pee_pkg::CNT_W'(pee_pkg::STACK_DEPTH)) begin
          sticky_d = raise(sticky_q, pee_pkg::ST_OVERFLOW);
        end else begin
          mem_we = (cnt_q != '0);
          tos_d  = cmd_q.push_value;
          cnt_d  = cnt_q + 1'b1;
        end
        state_d = after_push(cmd_q);
      end
      S_FETCH: begin
        if (cnt_q < pee_pkg::CNT_W'(2)) begin
          sticky_d = raise(sticky_q, pee_pkg::ST_UNDERFLOW);
          state_d  = after_op(cmd_q);
        end else begin
          mem_re  = 1'b1;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = after_op(cmd_q);
        case (cmd_q.op)
          pee_pkg::OP_ADD: begin
            tos_d = sum;
            cnt_d = cnt_m1;
          end
          pee_pkg::OP_SUB: begin
            tos_d = dif;
            cnt_d = cnt_m1;
          end
          pee_pkg::OP_MUL: begin
            tos_d = prod;
            cnt_d = cnt_m1;
          end
          default: begin
            if (tos_q == '0) begin
              sticky_d = raise(sticky_q, pee_pkg::ST_DIVZERO);
            end else begin
              div_start = 1'b1;
              state_d   = S_DIV;
            end
          end
        endcase
      end
      S_DIV: begin
        if (div_done) begin
          tos_d   = div_quo;
          cnt_d   = cnt_m1;
          state_d = after_op(cmd_q);
        end
      end
      S_END: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_d.status = fin_status;
          out_d.value  = (fin_status == pee_pkg::ST_OK) ? $signed(tos_q) : '0;
          cnt_d        = '0;
          sticky_d     = pee_pkg::ST_OK;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      sticky_q    <= pee_pkg::ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      sticky_q    <= sticky_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    tos_q <= tos_d;
    out_q <= out_d;
  end

  // Entries below the top live here; the top itself is held in tos_q.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem[cnt_m1[pee_pkg::IDX_W-1:0]] <= tos_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_q <= stack_mem[cnt_m2[pee_pkg::IDX_W-1:0]];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* rtl/postfix_expression_evaluator_core.sv */
// Top level of the postfix (reverse Polish) expression evaluator.
// Depends on pee_pkg, pee_front, pee_queue, pee_back and the defines header.
//
// Characters enter on the in_* channel (valid/ready), one transaction per
// character, with end_of_expression set on the final one; one result
// (value and status) per expression leaves on the out_* channel.
// The front end takes a character every cycle while the 2-entry command
// queue has room; digits, separators and ignored characters need no back
// end work unless they close a number or end the expression.
// The back end pops a command in S_IDLE, then runs S_PUSH for a push,
// S_FETCH (stack read) and S_EXEC for + - *, plus S_DIV for / on the
// bit-serial divider; an underflowing operator stops at S_FETCH, a zero
// divisor at S_EXEC. The final command adds S_END to load the output
// register, and the result is valid the cycle after. Throughput is set
// by the back end work per character. Reset clears the stack count,
// number accumulator, status and queue; the stack memory is not cleared
// and needs no clearing pass. A stalled receiver holds the result in the
// output register; the back end waits only when a further result is
// ready, and the front end waits once the queue fills.
`default_nettype none

`include "postfix_expression_evaluator_core_defines.svh"

module postfix_expression_evaluator_core (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire  pee_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output pee_pkg::out_t       out_data_o
);

  pee_pkg::cmd_t          front_cmd;
  pee_pkg::cmd_t          queue_head;
  pee_pkg::queue_status_t queue_status;
  logic                   cmd_push;
  logic                   cmd_pop;

  // Classify characters and accumulate numbers.
  pee_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .queue_full_i (queue_status.full),
    .cmd_push_o   (cmd_push),
    .cmd_o        (front_cmd)
  );

  // Decouple the two ends.
  pee_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (cmd_push),
    .cmd_i    (front_cmd),
    .pop_i    (cmd_pop),
    .head_o   (queue_head),
    .status_o (queue_status)
  );

  // Execute pushes and operators, emit the result.
  pee_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (queue_head),
    .queue_i     (queue_status),
    .pop_o       (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // The front end never writes a full queue.
  `PEE_ASSERT(a_no_queue_overrun, !(cmd_push && queue_status.full), "queue overrun")
  // The back end never takes from an empty queue.
  `PEE_ASSERT(a_no_queue_underrun, !(cmd_pop && !queue_status.valid), "queue underrun")
  // Any error result carries a zero value.
  `PEE_ASSERT_IMP(a_error_value_zero, out_valid_o && (out_data_o.status != pee_pkg::ST_OK),
                  out_data_o.value == '0, "error result with non-zero value")

endmodule

`default_nettype wire
